>>> src/fvt_pkg.sv
`timescale 1ns / 1ps
// fvt_pkg: request/result types, unit codes, calendar tables and the control store
// for the forecast verification time sequencer. No dependencies.
package fvt_pkg;

  typedef struct packed {
    logic [13:0] base_year;
    logic [3:0]  base_month;
    logic [4:0]  base_day;
    logic [4:0]  base_hour;
    logic [7:0]  period_one;
    logic [7:0]  period_two;
    logic [7:0]  range_indicator;
    logic [7:0]  unit_code;
  } req_t;

  typedef struct packed {
    logic signed [23:0] year_out;
    logic [3:0]         month_out;
    logic [4:0]         day_out;
    logic [4:0]         hour_out;
    logic               unit_error;
  } res_t;

  // table 4 unit codes
  localparam logic [7:0] U_MINUTE  = 8'd0;
  localparam logic [7:0] U_HOUR    = 8'd1;
  localparam logic [7:0] U_DAY     = 8'd2;
  localparam logic [7:0] U_MONTH   = 8'd3;
  localparam logic [7:0] U_YEAR    = 8'd4;
  localparam logic [7:0] U_DECADE  = 8'd5;
  localparam logic [7:0] U_NORMAL  = 8'd6;
  localparam logic [7:0] U_CENTURY = 8'd7;
  localparam logic [7:0] U_HOURS3  = 8'd10;
  localparam logic [7:0] U_HOURS6  = 8'd11;
  localparam logic [7:0] U_HOURS12 = 8'd12;
  localparam logic [7:0] U_SECOND  = 8'd254;

  // time range indicator codes
  localparam logic [7:0] TR_P2_LO    = 8'd2;
  localparam logic [7:0] TR_P2_HI    = 8'd5;
  localparam logic [7:0] TR_NEG_A    = 8'd6;
  localparam logic [7:0] TR_NEG_B    = 8'd7;
  localparam logic [7:0] TR_COMBINED = 8'd10;

  localparam logic [3:0] MON_FEB    = 4'd2;
  localparam logic [3:0] MON_DEC    = 4'd12;
  localparam logic [8:0] LEAP_JDAY  = 9'd60;
  localparam logic [4:0] LEAP_MDAY  = 5'd29;
  localparam logic [8:0] YEAR_DAYS  = 9'd365;
  localparam logic [8:0] CYC_LAST   = 9'd399;

  // datapath widths
  localparam int OFF_W       = 21;
  localparam int NUM_W       = 21;
  localparam int QUO_W       = 16;
  localparam int RECIP_W     = 22;
  localparam int RECIP_SHIFT = 25;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam int SCL_W       = OFF_W + 8;
  localparam int STEP_W      = 5;

  // biases that keep dividends non-negative, as whole multiples of the divisor
  localparam int MON_BIAS   = 264;
  localparam int MON_BIAS_Q = 22;
  localparam int HR_BIAS    = 3072;
  localparam int HR_BIAS_Q  = 128;
  localparam int YR_BIAS    = 400;

  typedef enum logic [1:0] {DV12, DV24, DV60, DV400} div_e;

  typedef enum logic [4:0] {
    OP_INIT, OP_YSCALE, OP_ERR, OP_LDM, OP_DIV, OP_MREM, OP_LDY, OP_YREM, OP_CLAMP,
    OP_ABS, OP_SETQ, OP_HSCALE, OP_LDH, OP_HREM, OP_JDAY, OP_WDN, OP_WUP, OP_MFIND,
    OP_DONE
  } op_e;

  typedef enum logic [1:0] {C_NEXT, C_JUMP, C_ENTRY, C_LOOP} cond_e;

  typedef struct packed {
    op_e               op;
    div_e              dv;
    cond_e             cond;
    logic [STEP_W-1:0] tgt;
  } ctrl_t;

  // control store addresses
  localparam logic [STEP_W-1:0] ST_INIT   = 5'd0;
  localparam logic [STEP_W-1:0] ST_YSCALE = 5'd1;
  localparam logic [STEP_W-1:0] ST_ERR    = 5'd2;
  localparam logic [STEP_W-1:0] ST_MLOAD  = 5'd3;
  localparam logic [STEP_W-1:0] ST_MDIV   = 5'd4;
  localparam logic [STEP_W-1:0] ST_MREM   = 5'd5;
  localparam logic [STEP_W-1:0] ST_MYLOAD = 5'd6;
  localparam logic [STEP_W-1:0] ST_MYDIV  = 5'd7;
  localparam logic [STEP_W-1:0] ST_MYREM  = 5'd8;
  localparam logic [STEP_W-1:0] ST_MCLAMP = 5'd9;
  localparam logic [STEP_W-1:0] ST_SABS   = 5'd10;
  localparam logic [STEP_W-1:0] ST_SDIV   = 5'd11;
  localparam logic [STEP_W-1:0] ST_SSETQ  = 5'd12;
  localparam logic [STEP_W-1:0] ST_NABS   = 5'd13;
  localparam logic [STEP_W-1:0] ST_NDIV   = 5'd14;
  localparam logic [STEP_W-1:0] ST_NSETQ  = 5'd15;
  localparam logic [STEP_W-1:0] ST_HSCALE = 5'd16;
  localparam logic [STEP_W-1:0] ST_HLOAD  = 5'd17;
  localparam logic [STEP_W-1:0] ST_HDIV   = 5'd18;
  localparam logic [STEP_W-1:0] ST_HREM   = 5'd19;
  localparam logic [STEP_W-1:0] ST_DYLOAD = 5'd20;
  localparam logic [STEP_W-1:0] ST_DYDIV  = 5'd21;
  localparam logic [STEP_W-1:0] ST_DYREM  = 5'd22;
  localparam logic [STEP_W-1:0] ST_JDAY   = 5'd23;
  localparam logic [STEP_W-1:0] ST_WDN    = 5'd24;
  localparam logic [STEP_W-1:0] ST_WUP    = 5'd25;
  localparam logic [STEP_W-1:0] ST_MFIND  = 5'd26;
  localparam logic [STEP_W-1:0] ST_DONE   = 5'd27;

  function automatic ctrl_t cw(op_e op, div_e dv, cond_e cond, logic [STEP_W-1:0] tgt);
    ctrl_t c;
    c.op   = op;
    c.dv   = dv;
    c.cond = cond;
    c.tgt  = tgt;
    return c;
  endfunction

  function automatic ctrl_t ucode(logic [STEP_W-1:0] step);
    ctrl_t c;
    unique case (step)
      ST_INIT:   c = cw(OP_INIT,   DV12,  C_ENTRY, ST_DONE);
      ST_YSCALE: c = cw(OP_YSCALE, DV12,  C_JUMP,  ST_DONE);
      ST_ERR:    c = cw(OP_ERR,    DV12,  C_JUMP,  ST_DONE);
      ST_MLOAD:  c = cw(OP_LDM,    DV12,  C_NEXT,  ST_DONE);
      ST_MDIV:   c = cw(OP_DIV,    DV12,  C_NEXT,  ST_DONE);
      ST_MREM:   c = cw(OP_MREM,   DV12,  C_NEXT,  ST_DONE);
      ST_MYLOAD: c = cw(OP_LDY,    DV400, C_NEXT,  ST_DONE);
      ST_MYDIV:  c = cw(OP_DIV,    DV400, C_NEXT,  ST_DONE);
      ST_MYREM:  c = cw(OP_YREM,   DV400, C_NEXT,  ST_DONE);
      ST_MCLAMP: c = cw(OP_CLAMP,  DV12,  C_JUMP,  ST_DONE);
      ST_SABS:   c = cw(OP_ABS,    DV60,  C_NEXT,  ST_DONE);
      ST_SDIV:   c = cw(OP_DIV,    DV60,  C_NEXT,  ST_DONE);
      ST_SSETQ:  c = cw(OP_SETQ,   DV60,  C_NEXT,  ST_DONE);
      ST_NABS:   c = cw(OP_ABS,    DV60,  C_NEXT,  ST_DONE);
      ST_NDIV:   c = cw(OP_DIV,    DV60,  C_NEXT,  ST_DONE);
      ST_NSETQ:  c = cw(OP_SETQ,   DV60,  C_JUMP,  ST_HLOAD);
      ST_HSCALE: c = cw(OP_HSCALE, DV24,  C_NEXT,  ST_DONE);
      ST_HLOAD:  c = cw(OP_LDH,    DV24,  C_NEXT,  ST_DONE);
      ST_HDIV:   c = cw(OP_DIV,    DV24,  C_NEXT,  ST_DONE);
      ST_HREM:   c = cw(OP_HREM,   DV24,  C_NEXT,  ST_DONE);
      ST_DYLOAD: c = cw(OP_LDY,    DV400, C_NEXT,  ST_DONE);
      ST_DYDIV:  c = cw(OP_DIV,    DV400, C_NEXT,  ST_DONE);
      ST_DYREM:  c = cw(OP_YREM,   DV400, C_NEXT,  ST_DONE);
      ST_JDAY:   c = cw(OP_JDAY,   DV400, C_NEXT,  ST_DONE);
      ST_WDN:    c = cw(OP_WDN,    DV400, C_LOOP,  ST_WDN);
      ST_WUP:    c = cw(OP_WUP,    DV400, C_LOOP,  ST_WUP);
      ST_MFIND:  c = cw(OP_MFIND,  DV400, C_NEXT,  ST_DONE);
      default:   c = cw(OP_DONE,   DV12,  C_NEXT,  ST_DONE);
    endcase
    return c;
  endfunction

  // first step of each unit's routine
  function automatic logic [STEP_W-1:0] unit_entry(logic [7:0] unit, logic zero_off);
    logic [STEP_W-1:0] s;
    case (unit) inside
      U_YEAR, U_DECADE, U_NORMAL, U_CENTURY: s = ST_YSCALE;
      U_MONTH:                               s = ST_MLOAD;
      U_SECOND:                              s = ST_SABS;
      U_MINUTE:                              s = ST_NABS;
      U_HOURS3, U_HOURS6, U_HOURS12:         s = ST_HSCALE;
      U_HOUR:                                s = ST_HLOAD;
      U_DAY:                                 s = ST_DYLOAD;
      default:                               s = ST_ERR;
    endcase
    if (zero_off) s = ST_DONE;
    return s;
  endfunction

  function automatic logic [7:0] unit_scale(logic [7:0] unit);
    logic [7:0] k;
    case (unit)
      U_DECADE:  k = 8'd10;
      U_NORMAL:  k = 8'd30;
      U_CENTURY: k = 8'd100;
      U_HOURS3:  k = 8'd3;
      U_HOURS6:  k = 8'd6;
      U_HOURS12: k = 8'd12;
      default:   k = 8'd1;
    endcase
    return k;
  endfunction

  // reciprocals scaled by 2**RECIP_SHIFT, exact over each routine's dividend range
  function automatic logic [RECIP_W-1:0] recip(div_e dv);
    logic [RECIP_W-1:0] r;
    unique case (dv)
      DV12:    r = 22'd2796203;
      DV24:    r = 22'd1398102;
      DV60:    r = 22'd559241;
      DV400:   r = 22'd83887;
      default: r = 22'd2796203;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] divisor(div_e dv);
    logic [8:0] d;
    unique case (dv)
      DV12:    d = 9'd12;
      DV24:    d = 9'd24;
      DV60:    d = 9'd60;
      DV400:   d = 9'd400;
      default: d = 9'd12;
    endcase
    return d;
  endfunction

  function automatic logic [8:0] cum_days(logic [3:0] idx);
    logic [8:0] c;
    case (idx)
      4'd0:    c = 9'd0;
      4'd1:    c = 9'd31;
      4'd2:    c = 9'd59;
      4'd3:    c = 9'd90;
      4'd4:    c = 9'd120;
      4'd5:    c = 9'd151;
      4'd6:    c = 9'd181;
      4'd7:    c = 9'd212;
      4'd8:    c = 9'd243;
      4'd9:    c = 9'd273;
      4'd10:   c = 9'd304;
      4'd11:   c = 9'd334;
      default: c = 9'd365;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] mon);
    logic [4:0] l;
    case (mon)
      4'd2:                    l = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: l = 5'd30;
      default:                 l = 5'd31;
    endcase
    return l;
  endfunction

  // leap rule on the year's residue mod 400
  function automatic logic is_leap(logic [8:0] cyc);
    return (cyc[1:0] == 2'b00) && !(cyc == 9'd100 || cyc == 9'd200 || cyc == 9'd300);
  endfunction

  // last month whose first day lies on or before the day of year
  function automatic logic [3:0] month_search(logic [8:0] jd);
    logic [3:0] idx;
    idx = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (cum_days(4'(k)) < jd) idx = 4'(k);
    end
    return idx;
  endfunction

endpackage

>>> src/forecast_verification_time.sv
`timescale 1ns / 1ps
// forecast_verification_time: reference date plus a grib1 forecast offset.
// Zero offsets go straight to the result; for days, hours, minutes and seconds the run time
// grows with the years walked, since the year walk steps one year per cycle.
// One request at a time: busy is low again in the cycle done_o shows, and the result cannot be
// stalled. Reset clears the sequencer and the strobe; no clearing pass.
module forecast_verification_time (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  fvt_pkg::req_t       req_i,
  output logic                busy,
  output logic                done_o,
  output fvt_pkg::res_t       res_o
);

  localparam int OFF_W       = fvt_pkg::OFF_W;
  localparam int NUM_W       = fvt_pkg::NUM_W;
  localparam int QUO_W       = fvt_pkg::QUO_W;
  localparam int PROD_W      = fvt_pkg::PROD_W;
  localparam int SCL_W       = fvt_pkg::SCL_W;
  localparam int STEP_W      = fvt_pkg::STEP_W;
  localparam int RECIP_SHIFT = fvt_pkg::RECIP_SHIFT;

  fvt_pkg::req_t       req_q;
  fvt_pkg::res_t       res_q;
  logic [STEP_W-1:0]   pc_q;
  logic                busy_q;
  logic                done_q;

  logic signed [OFF_W-1:0] off_q;
  logic signed [23:0]      yr_q;
  logic [3:0]              mon_q;
  logic [4:0]              day_q;
  logic [4:0]              hr_q;
  logic                    err_q;
  logic [NUM_W-1:0]        num_q;
  logic [QUO_W-1:0]        quo_q;
  logic [8:0]              cyc_q;
  logic                    neg_q;

  fvt_pkg::ctrl_t          ctl;
  logic signed [OFF_W-1:0] off0;
  logic [3:0]              m_sat;
  logic signed [SCL_W-1:0] scaled;
  logic [PROD_W-1:0]       prod;
  logic [NUM_W-1:0]        rem_full;
  logic                    leap_c;
  logic                    leap_dec;
  logic [8:0]              ylen;
  logic [8:0]              ylen_dec;
  logic [8:0]              cyc_dec;
  logic [8:0]              cyc_inc;
  logic                    off_lt1;
  logic                    off_gt;
  logic                    loop_hit;
  logic [4:0]              clamp_len;
  logic [8:0]              jd_adj;
  logic [3:0]              m_idx;
  logic [STEP_W-1:0]       pc_d;

  assign ctl = fvt_pkg::ucode(pc_q);

  // signed offset from the period bytes
  always_comb begin
    case (req_q.range_indicator) inside
      fvt_pkg::TR_COMBINED:                   off0 = OFF_W'({req_q.period_one,
                                                             req_q.period_two});
      [fvt_pkg::TR_P2_LO:fvt_pkg::TR_P2_HI]:  off0 = OFF_W'(req_q.period_two);
      fvt_pkg::TR_NEG_A, fvt_pkg::TR_NEG_B:   off0 = -OFF_W'(req_q.period_one);
      default:                                off0 = OFF_W'(req_q.period_one);
    endcase
  end

  always_comb begin
    if (req_q.base_month == 4'd0) begin
      m_sat = 4'd1;
    end else if (req_q.base_month > fvt_pkg::MON_DEC) begin
      m_sat = fvt_pkg::MON_DEC;
    end else begin
      m_sat = req_q.base_month;
    end
  end

  assign scaled   = SCL_W'(off_q)
                    * SCL_W'($signed({1'b0, fvt_pkg::unit_scale(req_q.unit_code)}));
  assign prod     = PROD_W'(num_q) * PROD_W'(fvt_pkg::recip(ctl.dv));
  assign rem_full = num_q - NUM_W'(NUM_W'(quo_q) * NUM_W'(fvt_pkg::divisor(ctl.dv)));

  assign cyc_dec  = (cyc_q == 9'd0) ? fvt_pkg::CYC_LAST : cyc_q - 9'd1;
  assign cyc_inc  = (cyc_q == fvt_pkg::CYC_LAST) ? 9'd0 : cyc_q + 9'd1;
  assign leap_c   = fvt_pkg::is_leap(cyc_q);
  assign leap_dec = fvt_pkg::is_leap(cyc_dec);
  assign ylen     = fvt_pkg::YEAR_DAYS + 9'(leap_c);
  assign ylen_dec = fvt_pkg::YEAR_DAYS + 9'(leap_dec);

  assign off_lt1  = off_q[OFF_W-1] || (off_q == '0);
  assign off_gt   = !off_q[OFF_W-1] && ($unsigned(off_q) > OFF_W'(ylen));
  assign loop_hit = (ctl.op == fvt_pkg::OP_WDN) ? off_lt1 : off_gt;

  assign clamp_len = fvt_pkg::month_len(mon_q) + 5'(leap_c && (mon_q == fvt_pkg::MON_FEB));
  // after the leap day, fold the day of year back onto the common-year table
  assign jd_adj    = off_q[8:0] - 9'(leap_c && (off_q[8:0] > fvt_pkg::LEAP_JDAY));
  assign m_idx     = fvt_pkg::month_search(jd_adj);

  always_comb begin
    case (ctl.cond)
      fvt_pkg::C_JUMP:  pc_d = ctl.tgt;
      fvt_pkg::C_ENTRY: pc_d = fvt_pkg::unit_entry(req_q.unit_code, off0 == '0);
      fvt_pkg::C_LOOP:  pc_d = loop_hit ? ctl.tgt : pc_q + STEP_W'(1);
      default:          pc_d = pc_q + STEP_W'(1);
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= fvt_pkg::ST_INIT;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (ctl.op == fvt_pkg::OP_DONE);
      if (!busy_q) begin
        if (start) begin
          busy_q <= 1'b1;
          pc_q   <= fvt_pkg::ST_INIT;
        end
      end else begin
        pc_q <= pc_d;
        if (ctl.op == fvt_pkg::OP_DONE) busy_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start && !busy_q) req_q <= req_i;
    if (busy_q) begin
      case (ctl.op)
        fvt_pkg::OP_INIT: begin
          off_q <= off0;
          yr_q  <= 24'(req_q.base_year);
          mon_q <= req_q.base_month;
          day_q <= req_q.base_day;
          hr_q  <= req_q.base_hour;
          err_q <= 1'b0;
        end
        fvt_pkg::OP_YSCALE: yr_q <= yr_q + 24'(scaled);
        fvt_pkg::OP_HSCALE: off_q <= OFF_W'(scaled);
        fvt_pkg::OP_ERR:    err_q <= 1'b1;
        fvt_pkg::OP_LDM: begin
          num_q <= NUM_W'(off_q) + NUM_W'(m_sat) + NUM_W'(fvt_pkg::MON_BIAS - 1);
        end
        fvt_pkg::OP_DIV:    quo_q <= prod[RECIP_SHIFT +: QUO_W];
        fvt_pkg::OP_MREM: begin
          yr_q  <= yr_q + 24'(quo_q) - 24'(fvt_pkg::MON_BIAS_Q);
          mon_q <= 4'(rem_full) + 4'd1;
        end
        fvt_pkg::OP_LDY:    num_q <= NUM_W'(yr_q + 24'(fvt_pkg::YR_BIAS));
        fvt_pkg::OP_YREM:   cyc_q <= 9'(rem_full);
        fvt_pkg::OP_CLAMP: begin
          day_q <= (clamp_len < req_q.base_day) ? clamp_len : req_q.base_day;
        end
        fvt_pkg::OP_ABS: begin
          neg_q <= off_q[OFF_W-1];
          num_q <= NUM_W'(off_q[OFF_W-1] ? -off_q : off_q);
        end
        fvt_pkg::OP_SETQ:   off_q <= neg_q ? -OFF_W'(quo_q) : OFF_W'(quo_q);
        fvt_pkg::OP_LDH: begin
          num_q <= NUM_W'(off_q) + NUM_W'(req_q.base_hour) + NUM_W'(fvt_pkg::HR_BIAS);
        end
        fvt_pkg::OP_HREM: begin
          hr_q  <= 5'(rem_full);
          off_q <= OFF_W'(quo_q) - OFF_W'(fvt_pkg::HR_BIAS_Q);
        end
        fvt_pkg::OP_JDAY: begin
          off_q <= off_q + OFF_W'(req_q.base_day) + OFF_W'(fvt_pkg::cum_days(m_sat - 4'd1))
                   + OFF_W'(leap_c && (m_sat > fvt_pkg::MON_FEB));
        end
        fvt_pkg::OP_WDN: begin
          if (off_lt1) begin
            yr_q  <= yr_q - 24'(1);
            cyc_q <= cyc_dec;
            off_q <= off_q + OFF_W'(ylen_dec);
          end
        end
        fvt_pkg::OP_WUP: begin
          if (off_gt) begin
            yr_q  <= yr_q + 24'(1);
            cyc_q <= cyc_inc;
            off_q <= off_q - OFF_W'(ylen);
          end
        end
        fvt_pkg::OP_MFIND: begin
          if (leap_c && (off_q[8:0] == fvt_pkg::LEAP_JDAY)) begin
            mon_q <= fvt_pkg::MON_FEB;
            day_q <= fvt_pkg::LEAP_MDAY;
          end else begin
            mon_q <= m_idx + 4'd1;
            day_q <= 5'(jd_adj - fvt_pkg::cum_days(m_idx));
          end
        end
        fvt_pkg::OP_DONE: begin
          res_q.year_out   <= yr_q;
          res_q.month_out  <= mon_q;
          res_q.day_out    <= day_q;
          res_q.hour_out   <= hr_q;
          res_q.unit_error <= err_q;
        end
        default: ;
      endcase
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

  // result strobe only once the sequencer has let go
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && pc_q == fvt_pkg::ST_INIT)) else $error("request not taken");

  a_cyc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (pc_q == fvt_pkg::ST_WDN || pc_q == fvt_pkg::ST_WUP))
      |-> (cyc_q <= fvt_pkg::CYC_LAST)) else $error("year residue out of range");

  // the downward walk leaves a positive day of year
  a_walk_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && pc_q == fvt_pkg::ST_WUP) |-> !off_lt1) else $error("day of year not positive");

  a_month_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && pc_q == fvt_pkg::ST_MREM) |=> (mon_q >= 4'd1 && mon_q <= fvt_pkg::MON_DEC))
    else $error("month roll out of range");

endmodule
